// ===== rtl/kwm_pkg.sv =====
`default_nettype none
package kwm_pkg;

  // List count and per-list depth; the depth must be a power of two.
  localparam int NumLists  = 4;
  localparam int ListDepth = 256;
  localparam int ValW      = 32;

  localparam int ListW = $clog2(NumLists);
  localparam int SlotW = $clog2(ListDepth);
  localparam int FillW = SlotW + 1;
  localparam int AddrW = ListW + SlotW;

  // Width of the list index and list fields on the ports.
  localparam int PortListW = 2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_POP,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [ListW-1:0]       list;
    logic signed [ValW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                   out_valid;
    logic signed [ValW-1:0] out_value;
    logic [PortListW-1:0]   out_list;
    logic                   rejected;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/kwm_front.sv =====
`default_nettype none
module kwm_front (
  input  wire logic                            in_valid_i,
  input  wire logic                            mode_i,
  input  wire logic [kwm_pkg::PortListW-1:0]   list_index_i,
  input  wire logic signed [kwm_pkg::ValW-1:0] value_i,
  output logic                                 in_stall_o,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output kwm_pkg::cmd_t                        q_cmd_o
);
  import kwm_pkg::*;

  // Stall while the queue has no free slot.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify: pop, append, or append to a list that does not exist.
  always_comb begin
    q_cmd_o.list  = ListW'(list_index_i);
    q_cmd_o.value = value_i;
    if (mode_i) begin
      q_cmd_o.op = OP_POP;
    end else if (int'(list_index_i) >= NumLists) begin
      q_cmd_o.op = OP_REJECT;
    end else begin
      q_cmd_o.op = OP_APPEND;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kwm_queue.sv =====
`default_nettype none
module kwm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  kwm_pkg::cmd_t      cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output kwm_pkg::cmd_t      cmd_o
);
  import kwm_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kwm_back.sv =====
`default_nettype none
module kwm_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  kwm_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          res_valid_o,
  input  wire logic     res_stall_i,
  output kwm_pkg::res_t res_o
);
  import kwm_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REFILL = 1'b1;

  logic                   state_q, state_d;
  logic [ListW-1:0]       refill_q, refill_d;
  logic [FillW-1:0]       fill_q [NumLists];
  logic [FillW-1:0]       fill_d [NumLists];
  logic [SlotW-1:0]       rp_q   [NumLists];
  logic [SlotW-1:0]       rp_d   [NumLists];
  logic signed [ValW-1:0] head_q [NumLists];

  logic                   res_vld_q, res_vld_d;
  res_t                   res_q, res_d;

  logic signed [ValW-1:0] mem [NumLists * ListDepth];
  logic signed [ValW-1:0] rd_data_q;
  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;

  logic                   head_we;
  logic [ListW-1:0]       head_sel;
  logic signed [ValW-1:0] head_wdata;

  logic                   found;
  logic [ListW-1:0]       best;
  logic signed [ValW-1:0] best_val;
  logic                   out_free;
  logic                   take;
  logic [SlotW-1:0]       tail_slot;

  // Smallest head among the non-empty lists; ties keep the lower index.
  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_val = '0;
    for (int i = 0; i < NumLists; i++) begin
      if (fill_q[i] != '0 && (!found || head_q[i] < best_val)) begin
        found    = 1'b1;
        best     = ListW'(i);
        best_val = head_q[i];
      end
    end
  end

  assign out_free  = !res_vld_q || !res_stall_i;
  assign take      = (state_q == ST_IDLE) && !q_empty_i && out_free;
  assign q_pop_o   = take;
  assign tail_slot = rp_q[q_cmd_i.list] + fill_q[q_cmd_i.list][SlotW-1:0];

  always_comb begin
    state_d    = state_q;
    refill_d   = refill_q;
    fill_d     = fill_q;
    rp_d       = rp_q;
    res_vld_d  = res_vld_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = {q_cmd_i.list, tail_slot};
    mem_re     = 1'b0;
    mem_raddr  = {best, rp_q[best] + SlotW'(1)};
    head_we    = 1'b0;
    head_sel   = q_cmd_i.list;
    head_wdata = q_cmd_i.value;

    // Drop the result once the consumer has taken it.
    if (res_vld_q && !res_stall_i) begin
      res_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          res_vld_d = 1'b1;
          res_d     = '0;
          unique case (q_cmd_i.op)
            OP_APPEND: begin
              if (fill_q[q_cmd_i.list] == FillW'(ListDepth)) begin
                res_d.rejected = 1'b1;
              end else begin
                mem_we = 1'b1;
                fill_d[q_cmd_i.list] = fill_q[q_cmd_i.list] + FillW'(1);
                // An empty list takes the value straight into its head.
                if (fill_q[q_cmd_i.list] == '0) begin
                  head_we = 1'b1;
                end
              end
            end
            OP_POP: begin
              if (found) begin
                res_d.out_valid = 1'b1;
                res_d.out_value = best_val;
                res_d.out_list  = PortListW'(best);
                rp_d[best]      = rp_q[best] + SlotW'(1);
                fill_d[best]    = fill_q[best] - FillW'(1);
                // Fetch the next head when the list keeps elements.
                if (fill_q[best] > FillW'(1)) begin
                  mem_re   = 1'b1;
                  refill_d = best;
                  state_d  = ST_REFILL;
                end
              end
            end
            OP_REJECT: begin
              res_d.rejected = 1'b1;
            end
            default: begin
              res_d.rejected = 1'b1;
            end
          endcase
        end
      end
      ST_REFILL: begin
        head_we    = 1'b1;
        head_sel   = refill_q;
        head_wdata = rd_data_q;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      refill_q  <= '0;
      res_vld_q <= 1'b0;
      for (int i = 0; i < NumLists; i++) begin
        fill_q[i] <= '0;
        rp_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      refill_q  <= refill_d;
      res_vld_q <= res_vld_d;
      fill_q    <= fill_d;
      rp_q      <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (head_we) begin
      head_q[head_sel] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_cmd_i.value;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_refill_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |=> (state_q == ST_IDLE))
    else $error("head refill did not finish in one cycle");

  a_refill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |-> (fill_q[refill_q] != '0))
    else $error("refill of an empty list");

  a_no_take_in_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |-> !q_pop_o)
    else $error("command taken while head refill pending");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(res_q.out_valid && res_q.rejected))
    else $error("result both popped and rejected");

endmodule
`default_nettype wire

// ===== rtl/k_way_sorted_merge.sv =====
`default_nettype none
// K-way merge of four sorted lists of signed 32-bit words. Each list is a
// 256-entry FIFO kept in one shared 1024-word memory; the head of every
// list also sits in a register so that a pop compares all heads at once.
// An append word (mode 0) adds value to the tail of list_index and
// reports append_rejected when that list is full. A pop word (mode 1)
// removes the smallest head, lowest list index on a tie, and returns it
// with out_valid and out_list; with all lists empty it returns out_valid
// low. Every input word yields exactly one result word. Input words land
// in a two-entry command queue, so the input side keeps accepting, until
// that queue is full, while a result waits in the output register. An
// append, a rejected append, a pop from all-empty lists and a pop that
// empties its list need no head refill. Any other pop also passes through
// a refill state that takes no new command while the chosen list's next
// head is read back from memory. Memory contents need no clearing after reset.
module k_way_sorted_merge (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            mode_i,
  input  wire logic [kwm_pkg::PortListW-1:0]   list_index_i,
  input  wire logic signed [kwm_pkg::ValW-1:0] value_i,
  output logic                                 res_valid_o,
  input  wire logic                            res_stall_i,
  output logic                                 out_valid_o,
  output logic signed [kwm_pkg::ValW-1:0]      out_value_o,
  output logic [kwm_pkg::PortListW-1:0]        out_list_o,
  output logic                                 append_rejected_o
);
  import kwm_pkg::*;

  // Front to queue.
  logic q_push;
  logic q_full;
  cmd_t push_cmd;

  // Queue to back.
  logic q_pop;
  logic q_empty;
  cmd_t head_cmd;

  res_t res;

  // Classify the incoming word.
  kwm_front u_front (
    .in_valid_i   (in_valid_i),
    .mode_i       (mode_i),
    .list_index_i (list_index_i),
    .value_i      (value_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  // Decouple the front from the back.
  kwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  // Execute appends and pops against the list memory.
  kwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res)
  );

  assign out_valid_o       = res.out_valid;
  assign out_value_o       = res.out_value;
  assign out_list_o        = res.out_list;
  assign append_rejected_o = res.rejected;

endmodule
`default_nettype wire
